@@ hdl/mrfp_pkg.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU frame parser package
// Shared types, protocol constants and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
package mrfp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned POS_W   = 9;

  localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

  localparam logic [BYTE_W-1:0] FC_EXCEPTION_BIT   = 8'h80;
  localparam logic [BYTE_W-1:0] FC_READ_COILS      = 8'h01;
  localparam logic [BYTE_W-1:0] FC_READ_INPUT_REGS = 8'h04;
  localparam logic [BYTE_W-1:0] FC_WRITE_COIL      = 8'h05;
  localparam logic [BYTE_W-1:0] FC_WRITE_REG       = 8'h06;
  localparam logic [BYTE_W-1:0] FC_WRITE_COILS     = 8'h0F;
  localparam logic [BYTE_W-1:0] FC_WRITE_REGS      = 8'h10;

  localparam logic [POS_W-1:0] LEN_EXCEPTION = 9'd5;
  localparam logic [POS_W-1:0] LEN_FIXED     = 9'd8;
  localparam logic [POS_W-1:0] LEN_RSP_BASE  = 9'd5;
  localparam logic [POS_W-1:0] LEN_REQ_BASE  = 9'd9;

  localparam logic [POS_W-1:0] POS_FUNCTION  = 9'd1;
  localparam logic [POS_W-1:0] POS_ADDR_HI   = 9'd2;
  localparam logic [POS_W-1:0] POS_ADDR_LO   = 9'd3;
  localparam logic [POS_W-1:0] POS_WORD_HI   = 9'd4;
  localparam logic [POS_W-1:0] POS_WORD_LO   = 9'd5;
  localparam logic [POS_W-1:0] POS_REQ_COUNT = 9'd6;

  typedef enum logic [1:0] {
    KIND_REQUEST   = 2'd0,
    KIND_RESPONSE  = 2'd1,
    KIND_EXCEPTION = 2'd2
  } frame_kind_t;

  typedef struct packed {
    frame_kind_t        frame_kind;
    logic [BYTE_W-1:0]  slave_address;
    logic [BYTE_W-1:0]  function_code;
    logic [BYTE_W-1:0]  exception_code;
    logic [WORD_W-1:0]  start_address;
    logic [WORD_W-1:0]  quantity;
    logic [BYTE_W-1:0]  byte_count;
    logic [WORD_W-1:0]  single_value;
    logic [WORD_W-1:0]  crc_received;
    logic               crc_ok;
    logic [POS_W-1:0]   frame_length;
  } mrfp_result_t;

  function automatic logic [WORD_W-1:0] crc_update(input logic [WORD_W-1:0] crc_in,
                                                   input logic [BYTE_W-1:0] data);
    logic [WORD_W-1:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < BYTE_W; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

@@ hdl/modbus_rtu_frame_parser.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU frame parser
// Assembles Modbus RTU frames from a byte stream and reports each complete
// frame with its header fields and a CRC-16/MODBUS check.
// ----------------------------------------------------------------------------
// The block accepts one byte per clock cycle while its result register can
// take a report: each byte is registered on acceptance, and when it advances a
// single pass of logic updates the frame state, the running CRC (one byte per
// pass) and the captured header fields. After the transaction that carries the
// frame's last byte, that byte is registered and, as it advances, the frame
// report is loaded into a one-entry result register, where it waits; the slave
// side stalls only while that register is full and not being taken.
module modbus_rtu_frame_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
  input  logic         s_axis_tuser,   // [0] is_request
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] slave_address, [15:8] function_code, [23:16] exception_code,
  // [39:24] start_address, [55:40] quantity, [63:56] byte_count,
  // [79:64] single_value, [95:80] crc_received, [96] crc_ok,
  // [105:97] frame_length, [111:106] zero
  output logic [111:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser    // [1:0] frame_kind
);
  import mrfp_pkg::*;

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         in_dir;
  logic         advance;
  logic         res_valid;
  mrfp_result_t res;
  mrfp_result_t out_data;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_dir  <= s_axis_tuser;
    end
  end

  mrfp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .rx_byte    (in_byte),
    .is_request (in_dir),
    .res_valid  (res_valid),
    .res        (res)
  );

  mrfp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_valid),
    .load_data (res),
    .take      (m_axis_tready),
    .valid     (m_axis_tvalid),
    .data      (out_data)
  );

  assign m_axis_tuser = out_data.frame_kind;
  assign m_axis_tdata = {6'b000000,
                         out_data.frame_length,
                         out_data.crc_ok,
                         out_data.crc_received,
                         out_data.single_value,
                         out_data.byte_count,
                         out_data.quantity,
                         out_data.start_address,
                         out_data.exception_code,
                         out_data.function_code,
                         out_data.slave_address};

endmodule

@@ hdl/mrfp_core.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU frame parser core
// Frame state, running CRC and header field capture, one byte per enable.
// ----------------------------------------------------------------------------
module mrfp_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic [7:0]           rx_byte,
  input  logic                 is_request,
  output logic                 res_valid,
  output mrfp_pkg::mrfp_result_t res
);
  import mrfp_pkg::*;

  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [POS_W-1:0]  target_length, target_length_next;
  logic [WORD_W-1:0] running_crc, running_crc_next;
  logic [BYTE_W-1:0] held_slave, held_slave_next;
  logic [BYTE_W-1:0] held_function, held_function_next;
  logic              held_direction, held_direction_next;
  logic [WORD_W-1:0] held_address, held_address_next;
  logic [WORD_W-1:0] held_quantity, held_quantity_next;
  logic [BYTE_W-1:0] held_count, held_count_next;
  logic [BYTE_W-1:0] held_exception, held_exception_next;
  logic [WORD_W-1:0] held_value, held_value_next;
  logic [BYTE_W-1:0] crc_low_byte, crc_low_byte_next;

  logic [POS_W:0]    pos_plus1, pos_plus2;
  logic [WORD_W-1:0] crc_rx;
  logic              fc_exc, fc_req_fixed, fc_multi, fc_single, fc_rsp_read, fc_ok;
  logic              h_exc, h_req, h_single, h_multi;

  assign pos_plus1 = {1'b0, byte_position} + 10'd1;
  assign pos_plus2 = {1'b0, byte_position} + 10'd2;
  assign crc_rx    = {rx_byte, crc_low_byte};

  assign fc_exc       = (rx_byte & FC_EXCEPTION_BIT) != 8'h00;
  assign fc_single    = (rx_byte == FC_WRITE_COIL) || (rx_byte == FC_WRITE_REG);
  assign fc_multi     = (rx_byte == FC_WRITE_COILS) || (rx_byte == FC_WRITE_REGS);
  assign fc_rsp_read  = (rx_byte >= FC_READ_COILS) && (rx_byte <= FC_READ_INPUT_REGS);
  assign fc_req_fixed = fc_rsp_read || fc_single;
  assign fc_ok        = fc_exc || fc_single || fc_multi || fc_rsp_read;

  assign h_exc    = (held_function & FC_EXCEPTION_BIT) != 8'h00;
  assign h_req    = held_direction;
  assign h_single = (held_function == FC_WRITE_COIL) || (held_function == FC_WRITE_REG);
  assign h_multi  = (held_function == FC_WRITE_COILS) || (held_function == FC_WRITE_REGS);

  always_comb begin
    byte_position_next  = byte_position;
    target_length_next  = target_length;
    running_crc_next    = running_crc;
    held_slave_next     = held_slave;
    held_function_next  = held_function;
    held_direction_next = held_direction;
    held_address_next   = held_address;
    held_quantity_next  = held_quantity;
    held_count_next     = held_count;
    held_exception_next = held_exception;
    held_value_next     = held_value;
    crc_low_byte_next   = crc_low_byte;
    res_valid           = 1'b0;
    res                 = '0;

    res.frame_kind     = h_exc ? KIND_EXCEPTION : (h_req ? KIND_REQUEST : KIND_RESPONSE);
    res.slave_address  = held_slave;
    res.function_code  = held_function;
    res.exception_code = held_exception;
    res.start_address  = held_address;
    res.quantity       = held_quantity;
    res.byte_count     = held_count;
    res.single_value   = held_value;
    res.crc_received   = crc_rx;
    res.crc_ok         = crc_rx == running_crc;
    res.frame_length   = target_length;

    if (en) begin
      if (byte_position == '0 ||
          (byte_position == POS_FUNCTION && !fc_ok) ||
          (byte_position == POS_FUNCTION && !fc_exc && !is_request && !fc_rsp_read &&
           !fc_single && !fc_multi)) begin
        // New frame, or resynchronisation on an unknown function code.
        held_slave_next     = rx_byte;
        held_function_next  = '0;
        held_direction_next = 1'b0;
        held_address_next   = '0;
        held_quantity_next  = '0;
        held_count_next     = '0;
        held_exception_next = '0;
        held_value_next     = '0;
        crc_low_byte_next   = '0;
        target_length_next  = '0;
        running_crc_next    = crc_update(CRC_INIT, rx_byte);
        byte_position_next  = POS_FUNCTION;
      end else if (byte_position == POS_FUNCTION) begin
        if (fc_exc) begin
          target_length_next = LEN_EXCEPTION;
        end else if (is_request) begin
          target_length_next = fc_req_fixed ? LEN_FIXED : '0;
        end else begin
          target_length_next = fc_rsp_read ? '0 : LEN_FIXED;
        end
        held_function_next  = rx_byte;
        held_direction_next = is_request;
        running_crc_next    = crc_update(running_crc, rx_byte);
        byte_position_next  = POS_ADDR_HI;
      end else if (target_length != '0 && pos_plus2 == {1'b0, target_length}) begin
        crc_low_byte_next  = rx_byte;
        byte_position_next = pos_plus1[POS_W-1:0];
      end else if (target_length != '0 && pos_plus1 == {1'b0, target_length}) begin
        res_valid           = 1'b1;
        byte_position_next  = '0;
        target_length_next  = '0;
        running_crc_next    = CRC_INIT;
        held_slave_next     = '0;
        held_function_next  = '0;
        held_direction_next = 1'b0;
        held_address_next   = '0;
        held_quantity_next  = '0;
        held_count_next     = '0;
        held_exception_next = '0;
        held_value_next     = '0;
        crc_low_byte_next   = '0;
      end else begin
        running_crc_next   = crc_update(running_crc, rx_byte);
        byte_position_next = pos_plus1[POS_W-1:0];
        if (h_exc) begin
          if (byte_position == POS_ADDR_HI) begin
            held_exception_next = rx_byte;
          end
        end else if (!h_req && held_function <= FC_READ_INPUT_REGS) begin
          if (byte_position == POS_ADDR_HI) begin
            held_count_next    = rx_byte;
            target_length_next = LEN_RSP_BASE + {1'b0, rx_byte};
          end
        end else begin
          priority if (byte_position == POS_ADDR_HI) begin
            held_address_next = {rx_byte, 8'h00};
          end else if (byte_position == POS_ADDR_LO) begin
            held_address_next = held_address | {8'h00, rx_byte};
          end else if (byte_position == POS_WORD_HI) begin
            if (h_single) begin
              held_value_next = {rx_byte, 8'h00};
            end else begin
              held_quantity_next = {rx_byte, 8'h00};
            end
          end else if (byte_position == POS_WORD_LO) begin
            if (h_single) begin
              held_value_next = held_value | {8'h00, rx_byte};
            end else begin
              held_quantity_next = held_quantity | {8'h00, rx_byte};
            end
          end else if (byte_position == POS_REQ_COUNT && h_req && h_multi) begin
            held_count_next    = rx_byte;
            target_length_next = LEN_REQ_BASE + {1'b0, rx_byte};
          end else begin
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      target_length  <= '0;
      running_crc    <= CRC_INIT;
      held_slave     <= '0;
      held_function  <= '0;
      held_direction <= 1'b0;
      held_address   <= '0;
      held_quantity  <= '0;
      held_count     <= '0;
      held_exception <= '0;
      held_value     <= '0;
      crc_low_byte   <= '0;
    end else begin
      byte_position  <= byte_position_next;
      target_length  <= target_length_next;
      running_crc    <= running_crc_next;
      held_slave     <= held_slave_next;
      held_function  <= held_function_next;
      held_direction <= held_direction_next;
      held_address   <= held_address_next;
      held_quantity  <= held_quantity_next;
      held_count     <= held_count_next;
      held_exception <= held_exception_next;
      held_value     <= held_value_next;
      crc_low_byte   <= crc_low_byte_next;
    end
  end

endmodule

@@ hdl/mrfp_out_reg.sv @@
// ----------------------------------------------------------------------------
// Modbus RTU frame parser result register
// Holds one finished frame report until the downstream side takes it.
// ----------------------------------------------------------------------------
module mrfp_out_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  mrfp_pkg::mrfp_result_t load_data,
  input  logic                   take,
  output logic                   valid,
  output mrfp_pkg::mrfp_result_t data
);
  import mrfp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule
